[hw/rtl/bra_pkg.sv]
`default_nettype none
package bra_pkg;
    localparam int NumMaps     = 4;
    localparam int MapBits     = 1024;
    localparam int WordBits    = 32;
    localparam int WordsPerMap = MapBits / WordBits;
    localparam int NumRegs     = 4;
    localparam int DataBits    = 8;
    localparam int MapW        = $clog2(NumMaps);
    localparam int WordW       = $clog2(WordsPerMap);
    localparam int BitW        = $clog2(WordBits);
    localparam int AddrW       = MapW + WordW;
    localparam int CapW        = $clog2(MapBits) + 1;
    localparam int RegW        = $clog2(NumRegs);
    localparam int ChunkBits   = 8;
    localparam int ChunkW      = $clog2(ChunkBits);
    localparam int SubW        = BitW - ChunkW;

    typedef enum logic [2:0] {
        ACT_SET   = 3'd0,
        ACT_CLEAR = 3'd1,
        ACT_TEST  = 3'd2,
        ACT_FIND  = 3'd3,
        ACT_WIPE  = 3'd4
    } t_action;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FAIL       = 2'd1;
    localparam logic [1:0] ST_CLEAR_SEEN = 2'd2;
    localparam logic [1:0] ST_NO_RUN     = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  map_index;
        logic [9:0]  start_bit;
        logic [10:0] run_length;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] found_bit;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic clr;       // clear sweep: zero one memory word
        logic load;      // latch request
        logic rd;        // issue word read
        logic wr;        // write modified word back
        logic adv;       // advance word pointer
        logic fscan;     // scan step (test word, or one find chunk)
        logic fclaim;    // find: rewind to claim start
        logic fin;       // latch result into output
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic fail;      // request is rejected up front
        logic is_test;
        logic is_find;
        logic last;      // current word is last of the range
        logic found;
        logic hit;       // current find chunk completes a run
        logic sub_last;  // current find chunk is last of the word
        logic scan_end;  // current word is last below capacity
        logic clr_done;  // clear sweep at its last word
    } t_sts;
endpackage
`default_nettype wire

[hw/rtl/bra_datapath.sv]
`default_nettype none
module bra_datapath import bra_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_cmd           i_cmd,
    input  wire t_req           i_req,
    input  wire logic [7:0]     i_bytes [NumRegs],
    output t_sts                o_sts,
    output t_rsp                o_rsp
);
    // flag memory, one word per address
    logic [WordBits-1:0] r_mem [NumMaps*WordsPerMap];
    logic [WordBits-1:0] r_rdata;
    logic [AddrW-1:0]    r_caddr;  // clear sweep address

    logic [2:0]       r_act;
    logic [MapW-1:0]  r_map;
    logic [CapW-1:0]  r_lo;      // first bit of range
    logic [CapW-1:0]  r_hi;      // one past last bit
    logic [WordW:0]   r_wptr;
    logic [SubW-1:0]  r_sub;     // find chunk within the word
    logic [CapW-1:0]  r_cap;
    logic [CapW-1:0]  r_len;     // effective length
    logic [CapW-1:0]  r_cnt;     // current free run
    logic             r_fail;
    logic             r_clr;
    logic             r_found;
    logic [9:0]       r_fbit;
    t_rsp             r_rsp;

    logic [CapW-1:0]  cap_c, len_c, eff_c;
    logic [CapW:0]    end_c;
    logic             fail_c;
    logic [CapW-1:0]  wbase;
    logic [WordBits-1:0] mask, wdata;
    logic [CapW-1:0]  cnt_n;
    logic             hit;
    logic [CapW-1:0]  hit_end;
    logic [AddrW-1:0] addr;

    // decode request against capacity
    always_comb begin
        logic [CapW+2:0] b;
        b = {{(CapW-5){1'b0}}, i_bytes[i_req.map_index]} << 3;
        cap_c = (b > (CapW+3)'(MapBits)) ? CapW'(MapBits) : b[CapW-1:0];
        len_c = i_req.run_length;
        eff_c = (len_c == '0) ? CapW'(1) : len_c;
        end_c = (CapW+1)'(i_req.start_bit) +
                ((i_req.action == ACT_TEST) ? {1'b0, len_c} : {1'b0, eff_c});
        fail_c = (cap_c == '0) || (i_req.action > ACT_WIPE) ||
                 ((i_req.action == ACT_FIND) ? (eff_c > cap_c)
                  : (i_req.action != ACT_WIPE && end_c > {1'b0, cap_c}));
    end

    // per-word range mask
    always_comb begin
        wbase = CapW'(r_wptr) << BitW;
        for (int k = 0; k < WordBits; k++) begin
            mask[k] = (wbase + CapW'(k) >= r_lo) && (wbase + CapW'(k) < r_hi);
        end
    end

    // first-fit scan over one chunk of the word
    always_comb begin
        logic [BitW-1:0] bi;
        logic [CapW-1:0] pos;
        cnt_n   = r_cnt;
        hit     = 1'b0;
        hit_end = '0;
        bi      = '0;
        pos     = '0;
        for (int k = 0; k < ChunkBits; k++) begin
            bi  = {r_sub, ChunkW'(k)};
            pos = wbase + CapW'(bi);
            if (!hit && (pos < r_cap)) begin
                if (r_rdata[bi]) cnt_n = '0;
                else begin
                    cnt_n = cnt_n + CapW'(1);
                    if (cnt_n >= r_len) begin
                        hit = 1'b1;
                        hit_end = pos + CapW'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        unique case (r_act)
            ACT_SET, ACT_FIND: wdata = r_rdata | mask;
            ACT_CLEAR:         wdata = r_rdata & ~mask;
            default:           wdata = '0;
        endcase
    end

    assign addr = {r_map, r_wptr[WordW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rdata <= r_mem[addr];
        if (i_cmd.clr) r_mem[r_caddr] <= '0;
        else if (i_cmd.wr) r_mem[addr] <= wdata;
    end

    // step the clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_caddr <= '0;
        else if (i_cmd.clr) r_caddr <= r_caddr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_req.action;
            r_map   <= i_req.map_index;
            r_cap   <= cap_c;
            r_len   <= eff_c;
            r_cnt   <= '0;
            r_sub   <= '0;
            r_fail  <= fail_c;
            r_clr   <= 1'b0;
            r_found <= 1'b0;
            r_fbit  <= '0;
            if (i_req.action == ACT_WIPE) begin
                r_lo <= '0; r_hi <= CapW'(MapBits);
                r_wptr <= '0;
            end else if (i_req.action == ACT_FIND) begin
                r_lo <= '0; r_hi <= '0;
                r_wptr <= '0;
            end else begin
                r_lo <= CapW'(i_req.start_bit);
                r_hi <= end_c[CapW-1:0];
                r_wptr <= (WordW+1)'(i_req.start_bit >> BitW);
            end
        end else begin
            if (i_cmd.fscan && r_act == ACT_FIND) begin
                r_cnt <= cnt_n;
                r_sub <= r_sub + 1'b1;
                if (hit) begin
                    r_found <= 1'b1;
                    r_lo    <= hit_end - r_len;
                    r_hi    <= hit_end;
                    r_fbit  <= 10'(hit_end - r_len);
                end
            end
            if (i_cmd.fclaim)
                r_wptr <= (WordW+1)'(r_lo >> BitW);
            else if (i_cmd.adv)
                r_wptr <= r_wptr + 1'b1;
            if (r_act == ACT_TEST && i_cmd.fscan && ((~r_rdata & mask) != '0))
                r_clr <= 1'b1;
        end
        // hold the finished result in the output register
        if (i_cmd.fin) begin
            r_rsp.found_bit <= r_fbit;
            if (r_fail)                 r_rsp.status <= ST_FAIL;
            else if (r_act == ACT_TEST) r_rsp.status <= r_clr ? ST_CLEAR_SEEN : ST_OK;
            else if (r_act == ACT_FIND) r_rsp.status <= r_found ? ST_OK : ST_NO_RUN;
            else                        r_rsp.status <= ST_OK;
        end
    end

    assign o_sts.fail       = r_fail;
    assign o_sts.is_test    = (r_act == ACT_TEST);
    assign o_sts.is_find    = (r_act == ACT_FIND);
    assign o_sts.last       = (r_act == ACT_WIPE)
                              ? (r_wptr == (WordW+1)'(WordsPerMap-1))
                              : ((wbase + CapW'(WordBits)) >= r_hi);
    assign o_sts.found      = r_found;
    assign o_sts.hit        = hit;
    assign o_sts.sub_last   = (r_sub == '1);
    assign o_sts.scan_end   = (wbase + CapW'(WordBits)) >= r_cap;
    assign o_sts.clr_done   = (r_caddr == '1);
    assign o_rsp            = r_rsp;
endmodule
`default_nettype wire

[hw/rtl/bra_ctrl.sv]
`default_nettype none
module bra_ctrl import bra_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_READ, S_WORK, S_SCAN, S_FIN
    } t_state;
    t_state r_state;
    logic   r_valid;

    // commands derive from state
    always_comb begin
        o_cmd        = '0;
        o_cmd.clr    = (r_state == S_CLEAR) && i_rst_n;
        o_cmd.load   = (r_state == S_IDLE) && i_valid;
        o_cmd.rd     = (r_state == S_READ);
        o_cmd.fscan  = ((r_state == S_WORK) && i_sts.is_test) ||
                       ((r_state == S_SCAN) && !i_sts.found);
        o_cmd.wr     = (r_state == S_WORK) && !i_sts.is_test &&
                       !(i_sts.is_find && !i_sts.found);
        o_cmd.adv    = ((r_state == S_WORK) && !(i_sts.is_find && !i_sts.found)) ||
                       ((r_state == S_SCAN) && !i_sts.found && !i_sts.hit &&
                        i_sts.sub_last);
        o_cmd.fclaim = (r_state == S_SCAN) && i_sts.found;
        o_cmd.fin    = (r_state == S_FIN) && (!r_valid || !i_stall);
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    // hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            if (o_cmd.fin) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR:    if (i_sts.clr_done) r_state <= S_IDLE;
                S_IDLE:     if (o_cmd.load) r_state <= S_DISPATCH;
                S_DISPATCH: r_state <= i_sts.fail ? S_FIN : S_READ;
                S_READ:     r_state <= S_WORK;
                S_WORK: begin
                    if (i_sts.is_find && !i_sts.found)
                        r_state <= S_SCAN;
                    else if (i_sts.last) r_state <= S_FIN;
                    else r_state <= S_READ;
                end
                S_SCAN: begin
                    // found a run: go back and claim it
                    if (i_sts.found) r_state <= S_READ;
                    else if (i_sts.hit || !i_sts.sub_last) r_state <= S_SCAN;
                    else if (i_sts.scan_end) r_state <= S_FIN;
                    else r_state <= S_READ;
                end
                S_FIN:      if (o_cmd.fin) r_state <= S_IDLE;
                default:    r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[hw/rtl/bitmap_range_allocator.sv]
// channel  | valid    | stall    | payload
// request  | i_valid  | o_stall  | i_req  (t_req)
// result   | o_valid  | i_stall  | o_rsp  (t_rsp)
// Set, clear: each 32-bit word of the run is read, then modified and written back. Test
// reads and checks each word. Find: each word is read, then scanned 8 bits per scan cycle;
// on a hit the pointer rewinds to set the run. Wipe zeroes the map; a rejected request skips the memory.
// Memory port (one read-modify-write per word) and the chunked scan set the rate.
// Reset clears control state, then a sweep over all 128 words zeroes the flag memory under stall.
// A stalled result holds in its register; the next request runs and waits to finish.
`default_nettype none
module bitmap_range_allocator import bra_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire t_req              i_req,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output t_rsp                   o_rsp,
    input  wire logic              i_cfg_we,
    input  wire logic [RegW-1:0]   i_cfg_index,
    input  wire logic [DataBits-1:0] i_cfg_data
);
    logic [7:0] r_bytes [NumRegs];
    t_cmd cmd;
    t_sts sts;

    // capture configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NumRegs; k++) r_bytes[k] <= '0;
        end else if (i_cfg_we) begin
            r_bytes[i_cfg_index] <= i_cfg_data;
        end
    end

    bra_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_sts(sts), .o_cmd(cmd)
    );

    bra_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_req, .i_bytes(r_bytes), .o_sts(sts), .o_rsp
    );
endmodule
`default_nettype wire
